[hw/rtl/spg_pkg.sv]
`default_nettype none

package spg_pkg;

  localparam int unsigned CNT_W  = 17;
  localparam int unsigned PW_W   = 16;
  localparam int unsigned DEG_W  = 8;
  localparam int unsigned MUL_AW = 17;
  localparam int unsigned MUL_BW = 9;
  localparam int unsigned PROD_W = 26;
  localparam int unsigned QUO_W  = 26;
  localparam int unsigned DSR_W  = 17;
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  localparam logic [2:0] CMD_WR_AUTO = 3'd0;
  localparam logic [2:0] CMD_WR_US   = 3'd1;
  localparam logic [2:0] CMD_TICK    = 3'd2;
  localparam logic [2:0] CMD_ENABLE  = 3'd3;
  localparam logic [2:0] CMD_DISABLE = 3'd4;

  localparam logic [2:0] REG_MIN_DEG  = 3'd0;
  localparam logic [2:0] REG_MAX_DEG  = 3'd1;
  localparam logic [2:0] REG_MIN_PUL  = 3'd2;
  localparam logic [2:0] REG_MAX_PUL  = 3'd3;
  localparam logic [2:0] REG_TICK_RES = 3'd4;
  localparam logic [2:0] REG_TICK_ADJ = 3'd5;
  localparam logic [2:0] REG_MAX_CYC  = 3'd6;
  localparam logic [2:0] REG_PERIOD   = 3'd7;

  localparam logic [15:0] DEG_CMD_MAX = 16'd180;
  localparam logic [15:0] US_AUTO_LO  = 16'd500;
  localparam logic [15:0] US_AUTO_HI  = 16'd2400;

  typedef struct packed {
    logic [7:0]  min_degree;
    logic [7:0]  max_degree;
    logic [15:0] min_pulse_us;
    logic [15:0] max_pulse_us;
    logic [7:0]  tick_res_us;
    logic [7:0]  tick_adjust_us;
    logic [7:0]  max_cycles;
    logic [15:0] period_us;
  } cfg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DECODE,
    OP_MAP_MUL,
    OP_MAP_DIV,
    OP_MAP_FIX,
    OP_RND_DIV,
    OP_SCALE,
    OP_FLR_DIV,
    OP_BACK_MUL,
    OP_BACK_DIV,
    OP_BACK_FIX,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    logic is_deg;
    logic is_micro;
    logic deg_eq;
    logic div_done;
    logic out_blocked;
  } dp_stat_t;

endpackage

`default_nettype wire

[hw/rtl/spg_regs.sv]
`default_nettype none

module spg_regs import spg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MIN_DEG:  cfg_nxt.min_degree     = pwdata[7:0];
        REG_MAX_DEG:  cfg_nxt.max_degree     = pwdata[7:0];
        REG_MIN_PUL:  cfg_nxt.min_pulse_us   = pwdata[15:0];
        REG_MAX_PUL:  cfg_nxt.max_pulse_us   = pwdata[15:0];
        REG_TICK_RES: cfg_nxt.tick_res_us    = pwdata[7:0];
        REG_TICK_ADJ: cfg_nxt.tick_adjust_us = pwdata[7:0];
        REG_MAX_CYC:  cfg_nxt.max_cycles     = pwdata[7:0];
        REG_PERIOD:   cfg_nxt.period_us      = pwdata[15:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MIN_DEG:  prdata = DATA_W'(cfg_r.min_degree);
      REG_MAX_DEG:  prdata = DATA_W'(cfg_r.max_degree);
      REG_MIN_PUL:  prdata = DATA_W'(cfg_r.min_pulse_us);
      REG_MAX_PUL:  prdata = DATA_W'(cfg_r.max_pulse_us);
      REG_TICK_RES: prdata = DATA_W'(cfg_r.tick_res_us);
      REG_TICK_ADJ: prdata = DATA_W'(cfg_r.tick_adjust_us);
      REG_MAX_CYC:  prdata = DATA_W'(cfg_r.max_cycles);
      REG_PERIOD:   prdata = DATA_W'(cfg_r.period_us);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_degree     <= 8'd0;
      cfg_r.max_degree     <= 8'd180;
      cfg_r.min_pulse_us   <= 16'd500;
      cfg_r.max_pulse_us   <= 16'd2400;
      cfg_r.tick_res_us    <= 8'd50;
      cfg_r.tick_adjust_us <= 8'd0;
      cfg_r.max_cycles     <= 8'd0;
      cfg_r.period_us      <= 16'd20000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/spg_div.sv]
`default_nettype none

module spg_div import spg_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [QUO_W-1:0] dividend,
  input  logic [DSR_W-1:0] divisor,
  output logic [QUO_W-1:0] quotient,
  output logic             done
);

  localparam int unsigned STEP_W = $clog2(QUO_W);

  logic [QUO_W-1:0]  quo_r, quo_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [DSR_W:0]    trial;
  logic [DSR_W:0]    diff;

  assign quotient = quo_r;
  assign done     = done_r;
  assign trial    = {rem_r, quo_r[QUO_W-1]};
  assign diff     = trial - {1'b0, dsr_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = diff[DSR_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DSR_W-1:0];
        quo_nxt = {quo_r[QUO_W-2:0], 1'b0};
      end
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(QUO_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/spg_dp.sv]
`default_nettype none

module spg_dp import spg_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  cfg_t            cfg,
  input  dp_op_t          op,
  input  logic [2:0]      in_cmd,
  input  logic [15:0]     in_value,
  input  logic            out_stall,
  output dp_stat_t        stat,
  output logic            out_valid,
  output logic            out_pin_level,
  output logic            out_pin_driven,
  output logic [PW_W-1:0] out_pulse_width,
  output logic [DEG_W-1:0] out_position
);

  logic [2:0]               cmd_r, cmd_nxt;
  logic [15:0]              val_r, val_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     neg_r, neg_nxt;
  logic [PW_W-1:0]          p_r, p_nxt;
  logic [PW_W-1:0]          pulse_len_r, pulse_len_nxt;
  logic [DEG_W-1:0]         degree_r, degree_nxt;
  logic [CNT_W-1:0]         tick_r, tick_nxt;
  logic [7:0]               period_cnt_r, period_cnt_nxt;
  logic                     done_r, done_nxt;
  logic                     off_r, off_nxt;
  logic                     latch_r, latch_nxt;
  logic                     ov_r, ov_nxt;
  logic                     o_level_r, o_level_nxt;
  logic                     o_driven_r, o_driven_nxt;
  logic [PW_W-1:0]          o_width_r, o_width_nxt;
  logic [DEG_W-1:0]         o_pos_r, o_pos_nxt;

  logic [7:0]               res_nz;
  logic signed [MUL_BW-1:0] deg_span;
  logic signed [MUL_BW-1:0] deg_off;
  logic signed [MUL_AW-1:0] pul_span;
  logic signed [MUL_AW-1:0] pul_off;
  logic [MUL_BW-1:0]        deg_span_neg;
  logic [MUL_AW-1:0]        pul_span_neg;
  logic [7:0]               deg_span_mag;
  logic [15:0]              pul_span_mag;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic [PROD_W-1:0]        prod_neg;
  logic [QUO_W-1:0]         prod_mag;
  logic                     div_start;
  logic [QUO_W-1:0]         div_dvd;
  logic [DSR_W-1:0]         div_dsr;
  logic [QUO_W-1:0]         quo;
  logic                     div_done;
  logic [24:0]              scale_p;
  logic [PW_W-1:0]          q16;
  logic [DEG_W-1:0]         q8;
  logic [CNT_W-1:0]         tick_inc;
  logic [7:0]               pc_inc;
  logic                     auto_deg;
  logic                     auto_us;

  assign res_nz       = (cfg.tick_res_us == 8'd0) ? 8'd1 : cfg.tick_res_us;
  assign deg_span     = $signed({1'b0, cfg.max_degree}) - $signed({1'b0, cfg.min_degree});
  assign deg_off      = $signed({1'b0, val_r[7:0]}) - $signed({1'b0, cfg.min_degree});
  assign pul_span     = $signed({1'b0, cfg.max_pulse_us}) - $signed({1'b0, cfg.min_pulse_us});
  assign pul_off      = $signed({1'b0, pulse_len_r}) - $signed({1'b0, cfg.min_pulse_us});
  assign deg_span_neg = -deg_span;
  assign pul_span_neg = -pul_span;
  assign deg_span_mag = deg_span[MUL_BW-1] ? deg_span_neg[7:0] : deg_span[7:0];
  assign pul_span_mag = pul_span[MUL_AW-1] ? pul_span_neg[15:0] : pul_span[15:0];

  assign mul_a = (op == OP_BACK_MUL) ? pul_off : pul_span;
  assign mul_b = (op == OP_BACK_MUL) ? deg_span : deg_off;
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign prod_neg = -prod_r;
  assign prod_mag = prod_r[PROD_W-1] ? prod_neg : prod_r;

  assign scale_p  = quo[16:0] * res_nz;
  assign q16      = quo[15:0];
  assign q8       = quo[7:0];
  assign tick_inc = CNT_W'(cfg.tick_res_us) - CNT_W'(cfg.tick_adjust_us);
  assign pc_inc   = (period_cnt_r == 8'hFF) ? 8'hFF : period_cnt_r + 8'd1;

  assign auto_deg = (cmd_r == CMD_WR_AUTO) && (val_r <= DEG_CMD_MAX);
  assign auto_us  = (cmd_r == CMD_WR_AUTO) && (val_r >= US_AUTO_LO) && (val_r <= US_AUTO_HI);

  assign stat.is_deg      = auto_deg;
  assign stat.is_micro    = auto_us || (cmd_r == CMD_WR_US);
  assign stat.deg_eq      = (cfg.max_degree == cfg.min_degree);
  assign stat.div_done    = div_done;
  assign stat.out_blocked = ov_r && out_stall;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = prod_mag;
    div_dsr   = DSR_W'(deg_span_mag);
    unique case (op)
      OP_MAP_DIV: begin
        div_start = 1'b1;
      end
      OP_RND_DIV: begin
        div_start = 1'b1;
        div_dvd   = QUO_W'({p_r, 1'b0}) + QUO_W'(res_nz);
        div_dsr   = DSR_W'({res_nz, 1'b0});
      end
      OP_FLR_DIV: begin
        div_start = 1'b1;
        div_dvd   = QUO_W'(val_r);
        div_dsr   = DSR_W'(res_nz);
      end
      OP_BACK_DIV: begin
        div_start = 1'b1;
        div_dsr   = DSR_W'(pul_span_mag);
      end
      default: div_start = 1'b0;
    endcase
  end

  spg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (quo),
    .done     (div_done)
  );

  always_comb begin
    cmd_nxt        = cmd_r;
    val_nxt        = val_r;
    prod_nxt       = prod_r;
    neg_nxt        = neg_r;
    p_nxt          = p_r;
    pulse_len_nxt  = pulse_len_r;
    degree_nxt     = degree_r;
    tick_nxt       = tick_r;
    period_cnt_nxt = period_cnt_r;
    done_nxt       = done_r;
    off_nxt        = off_r;
    latch_nxt      = latch_r;
    ov_nxt         = ov_r;
    o_level_nxt    = o_level_r;
    o_driven_nxt   = o_driven_r;
    o_width_nxt    = o_width_r;
    o_pos_nxt      = o_pos_r;

    if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end

    unique case (op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        cmd_nxt = in_cmd;
        val_nxt = in_value;
      end
      OP_DECODE: begin
        unique case (cmd_r)
          CMD_WR_AUTO, CMD_WR_US: begin
            if (auto_deg && stat.deg_eq) begin
              p_nxt = cfg.min_pulse_us;
            end
          end
          CMD_TICK: begin
            if (!off_r) begin
              if (tick_r <= CNT_W'(pulse_len_r)) begin
                if (done_r) begin
                  latch_nxt = 1'b1;
                  done_nxt  = 1'b0;
                end
              end else if (!done_r) begin
                latch_nxt = 1'b0;
                done_nxt  = 1'b1;
              end
              if (tick_r >= CNT_W'(cfg.period_us)) begin
                if (cfg.max_cycles == 8'd0) begin
                  tick_nxt = '0;
                end else begin
                  period_cnt_nxt = pc_inc;
                  if (pc_inc < cfg.max_cycles) begin
                    tick_nxt = '0;
                  end
                end
              end else begin
                tick_nxt = tick_r + tick_inc;
              end
            end
          end
          CMD_ENABLE: off_nxt = 1'b0;
          CMD_DISABLE: begin
            off_nxt   = 1'b1;
            done_nxt  = 1'b1;
            latch_nxt = 1'b0;
          end
          default: off_nxt = off_r;
        endcase
      end
      OP_MAP_MUL, OP_BACK_MUL: begin
        prod_nxt = mul_p;
      end
      OP_MAP_DIV: begin
        neg_nxt = prod_r[PROD_W-1] ^ deg_span[MUL_BW-1];
      end
      OP_BACK_DIV: begin
        neg_nxt = prod_r[PROD_W-1] ^ pul_span[MUL_AW-1];
      end
      OP_MAP_FIX: begin
        p_nxt = (neg_r ? -q16 : q16) + cfg.min_pulse_us;
      end
      OP_RND_DIV, OP_FLR_DIV: begin
      end
      OP_SCALE: begin
        pulse_len_nxt = scale_p[PW_W-1:0];
        if (auto_deg) begin
          degree_nxt     = val_r[7:0];
          off_nxt        = 1'b0;
          tick_nxt       = '0;
          period_cnt_nxt = '0;
        end
      end
      OP_BACK_FIX: begin
        if (cfg.max_pulse_us == cfg.min_pulse_us) begin
          degree_nxt = cfg.min_degree;
        end else begin
          degree_nxt = (neg_r ? -q8 : q8) + cfg.min_degree;
        end
        off_nxt        = 1'b0;
        tick_nxt       = '0;
        period_cnt_nxt = '0;
      end
      OP_EMIT: begin
        ov_nxt       = 1'b1;
        o_level_nxt  = latch_r;
        o_driven_nxt = !off_r;
        o_width_nxt  = pulse_len_r;
        o_pos_nxt    = degree_r;
      end
      default: ov_nxt = ov_r;
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    val_r      <= val_nxt;
    prod_r     <= prod_nxt;
    neg_r      <= neg_nxt;
    p_r        <= p_nxt;
    o_level_r  <= o_level_nxt;
    o_driven_r <= o_driven_nxt;
    o_width_r  <= o_width_nxt;
    o_pos_r    <= o_pos_nxt;
    if (!rst_n) begin
      pulse_len_r  <= '0;
      degree_r     <= '0;
      tick_r       <= '0;
      period_cnt_r <= '0;
      done_r       <= 1'b1;
      off_r        <= 1'b1;
      latch_r      <= 1'b0;
      ov_r         <= 1'b0;
    end else begin
      pulse_len_r  <= pulse_len_nxt;
      degree_r     <= degree_nxt;
      tick_r       <= tick_nxt;
      period_cnt_r <= period_cnt_nxt;
      done_r       <= done_nxt;
      off_r        <= off_nxt;
      latch_r      <= latch_nxt;
      ov_r         <= ov_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_pin_level   = o_level_r;
  assign out_pin_driven  = o_driven_r;
  assign out_pulse_width = o_width_r;
  assign out_position    = o_pos_r;

endmodule

`default_nettype wire

[hw/rtl/spg_ctrl.sv]
`default_nettype none

module spg_ctrl import spg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  typedef enum logic [15:0] {
    S_IDLE      = 16'h0001,
    S_DECODE    = 16'h0002,
    S_MAP_MUL   = 16'h0004,
    S_MAP_GO    = 16'h0008,
    S_MAP_WAIT  = 16'h0010,
    S_MAP_FIX   = 16'h0020,
    S_RND_GO    = 16'h0040,
    S_RND_WAIT  = 16'h0080,
    S_SCALE     = 16'h0100,
    S_FLR_GO    = 16'h0200,
    S_FLR_WAIT  = 16'h0400,
    S_BACK_MUL  = 16'h0800,
    S_BACK_GO   = 16'h1000,
    S_BACK_WAIT = 16'h2000,
    S_BACK_FIX  = 16'h4000,
    S_EMIT      = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE) || stat.out_blocked;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op        = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        op = OP_DECODE;
        if (stat.is_deg) begin
          state_nxt = stat.deg_eq ? S_RND_GO : S_MAP_MUL;
        end else if (stat.is_micro) begin
          state_nxt = S_FLR_GO;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_MAP_MUL: begin
        op        = OP_MAP_MUL;
        state_nxt = S_MAP_GO;
      end
      S_MAP_GO: begin
        op        = OP_MAP_DIV;
        state_nxt = S_MAP_WAIT;
      end
      S_MAP_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_MAP_FIX;
        end
      end
      S_MAP_FIX: begin
        op        = OP_MAP_FIX;
        state_nxt = S_RND_GO;
      end
      S_RND_GO: begin
        op        = OP_RND_DIV;
        state_nxt = S_RND_WAIT;
      end
      S_RND_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        op        = OP_SCALE;
        state_nxt = stat.is_deg ? S_EMIT : S_BACK_MUL;
      end
      S_FLR_GO: begin
        op        = OP_FLR_DIV;
        state_nxt = S_FLR_WAIT;
      end
      S_FLR_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_SCALE;
        end
      end
      S_BACK_MUL: begin
        op        = OP_BACK_MUL;
        state_nxt = S_BACK_GO;
      end
      S_BACK_GO: begin
        op        = OP_BACK_DIV;
        state_nxt = S_BACK_WAIT;
      end
      S_BACK_WAIT: begin
        if (stat.div_done) begin
          state_nxt = S_BACK_FIX;
        end
      end
      S_BACK_FIX: begin
        op        = OP_BACK_FIX;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        op        = OP_EMIT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/servo_pulse_generator_core.sv]
// Channel   Handshake                        Beat contents
// in        in_valid / in_stall              in_cmd, in_value
// out       out_valid / out_stall            out_pin_level, out_pin_driven,
//                                            out_pulse_width, out_position
// cfg       psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// Tick, enable, disable and ignored commands go from decode straight to emit.
// Degree writes run two passes through the shared 26-step divider (one when the
// degree bounds are equal); microsecond writes run two.
// Synchronous active-low reset restores register defaults; the channel
// starts disabled with the latch low.
// A held result in the output register stalls only the next accept.
`default_nettype none

module servo_pulse_generator_core import spg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [2:0]        in_cmd,
  input  logic [15:0]       in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_pin_level,
  output logic              out_pin_driven,
  output logic [15:0]       out_pulse_width,
  output logic [7:0]        out_position,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg;
  dp_op_t   op;
  dp_stat_t stat;

  spg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  spg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  spg_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .op              (op),
    .in_cmd          (in_cmd),
    .in_value        (in_value),
    .out_stall       (out_stall),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_pin_level   (out_pin_level),
    .out_pin_driven  (out_pin_driven),
    .out_pulse_width (out_pulse_width),
    .out_position    (out_position)
  );

endmodule

`default_nettype wire
